// ===== sv/typed_slot_predicate_filter_macros.svh =====
// Assertion macros used by the checker of the slot filter.
`ifndef TYPED_SLOT_PREDICATE_FILTER_MACROS_SVH
`define TYPED_SLOT_PREDICATE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tspf_pkg.sv =====
`default_nettype none

package tspf_pkg;

    localparam int SLOT_COUNT_DEF       = 16;
    localparam int ENTRIES_PER_SLOT_DEF = 4;

    // operation codes
    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_ATTACH_EQ  = 3'd1;
    localparam logic [2:0] OP_ATTACH_BTW = 3'd2;
    localparam logic [2:0] OP_DETACH     = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    // slot value types
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // predicate entry kinds
    localparam logic [1:0] ENT_EMPTY   = 2'd0;
    localparam logic [1:0] ENT_INT_EQ  = 2'd1;
    localparam logic [1:0] ENT_INT_BTW = 2'd2;
    localparam logic [1:0] ENT_CHAR_EQ = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_RANGE  = 3'd3;
    localparam logic [2:0] ST_NO_ENTRY   = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         slot_index;
        logic [1:0]         value_type;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       allowed;
        logic [3:0] assigned_slot;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SCAN,
        S_TEST,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic slot_rd;
        logic exec;
        logic ent_rd;
        logic ent_test;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== sv/tspf_ctrl.sv =====
`default_nettype none

module tspf_ctrl import tspf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.need_scan ? S_SCAN : S_EMIT;
            S_SCAN:   n_state = S_TEST;
            S_TEST: begin
                n_state = (i_sts.hit || i_sts.last) ? S_EMIT : S_SCAN;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = (r_state != S_IDLE);
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.slot_rd  = (r_state == S_LOOKUP);
        o_cmd.exec     = (r_state == S_DECIDE);
        o_cmd.ent_rd   = (r_state == S_SCAN);
        o_cmd.ent_test = (r_state == S_TEST);
        o_cmd.emit     = (r_state == S_EMIT) && !i_sts.out_busy;
    end

endmodule

`default_nettype wire

// ===== sv/tspf_dp.sv =====
`default_nettype none

module tspf_dp import tspf_pkg::*; #(
    parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
    parameter int ENTRIES_PER_SLOT = ENTRIES_PER_SLOT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int TOTAL  = SLOT_COUNT * ENTRIES_PER_SLOT;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NF_W   = $clog2(SLOT_COUNT + 1);
    localparam int ENT_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W  = $clog2(ENTRIES_PER_SLOT + 1);

    // item and addressing
    t_in_item          r_item;
    logic              r_in_range;
    logic [SLOT_W-1:0] r_slot_addr;
    logic [ENT_W-1:0]  r_ent_base;
    logic              n_in_range;
    logic [SLOT_W-1:0] n_slot_addr;

    // slot table: kind and fill count per slot, valid bit per slot
    logic [NF_W-1:0]       r_next_free;
    logic [SLOT_COUNT-1:0] r_slot_vld;
    logic [1:0]            r_slot_kind_mem [SLOT_COUNT];
    logic [CNT_W-1:0]      r_slot_cnt_mem  [SLOT_COUNT];
    logic [1:0]            r_rd_kind_raw;
    logic [CNT_W-1:0]      r_rd_cnt_raw;
    logic                  r_rd_vld;
    logic [1:0]            cur_kind;
    logic [CNT_W-1:0]      cur_cnt;

    // predicate entries
    logic [1:0]  r_ent_kind_mem   [TOTAL];
    logic [31:0] r_ent_first_mem  [TOTAL];
    logic [31:0] r_ent_second_mem [TOTAL];
    logic [1:0]  r_ent_kind;
    logic [31:0] r_ent_first;
    logic [31:0] r_ent_second;
    logic [CNT_W-1:0] r_scan;
    logic [ENT_W-1:0] ent_raddr;
    logic [ENT_W-1:0] ent_waddr;

    // working result
    logic [2:0] r_status;
    logic       r_allowed;
    logic [3:0] r_assigned;

    logic        r_out_valid;
    t_out_item   r_out_item;

    // decide step
    logic              is_full;
    logic              bad_range;
    logic              type_ok;
    logic              no_entry;
    logic              kind_match;
    logic [2:0]        exec_status;
    logic              exec_allowed;
    logic [3:0]        exec_assigned;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [1:0]        slot_wkind;
    logic [CNT_W-1:0]  slot_wcnt;
    logic              set_vld;
    logic              ent_we;
    logic [1:0]        ent_wkind;
    logic [31:0]       ent_wfirst;
    logic              hit;

    assign n_in_range  = (int'(i_in_item.slot_index) < SLOT_COUNT);
    assign n_slot_addr = n_in_range ? SLOT_W'(i_in_item.slot_index) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item      <= i_in_item;
            r_in_range  <= n_in_range;
            r_slot_addr <= n_slot_addr;
            r_ent_base  <= ENT_W'(int'(n_slot_addr) * ENTRIES_PER_SLOT);
        end
    end

    // registered slot read; a slot never registered reads as type none, no entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_rd) begin
            r_rd_kind_raw <= r_slot_kind_mem[r_slot_addr];
            r_rd_cnt_raw  <= r_slot_cnt_mem[r_slot_addr];
            r_rd_vld      <= r_slot_vld[r_slot_addr];
        end
    end

    assign cur_kind = r_rd_vld ? r_rd_kind_raw : KIND_NONE;
    assign cur_cnt  = r_rd_vld ? r_rd_cnt_raw : '0;

    assign is_full    = (r_next_free == NF_W'(SLOT_COUNT));
    assign bad_range  = ($signed(r_item.value_a) >= $signed(r_item.value_b));
    assign type_ok    = r_in_range && ((cur_kind == KIND_INT) ||
                        ((r_item.op == OP_ATTACH_EQ) && (cur_kind == KIND_CHAR)));
    assign no_entry   = (cur_cnt >= CNT_W'(ENTRIES_PER_SLOT));
    assign kind_match = r_in_range && (cur_kind == r_item.value_type);
    assign ent_waddr  = r_ent_base + ENT_W'(cur_cnt);
    assign ent_raddr  = r_ent_base + ENT_W'(r_scan);

    always_comb begin
        exec_status   = ST_OK;
        exec_allowed  = 1'b0;
        exec_assigned = '0;
        slot_we       = 1'b0;
        slot_waddr    = r_slot_addr;
        slot_wkind    = cur_kind;
        slot_wcnt     = '0;
        set_vld       = 1'b0;
        ent_we        = 1'b0;
        ent_wkind     = ENT_INT_EQ;
        ent_wfirst    = r_item.value_a;
        unique case (r_item.op)
            OP_REGISTER: begin
                if (is_full) begin
                    exec_status = ST_FULL;
                end else begin
                    exec_assigned = 4'(r_next_free);
                    slot_we       = 1'b1;
                    slot_waddr    = SLOT_W'(r_next_free);
                    slot_wkind    = r_item.value_type;
                    set_vld       = 1'b1;
                end
            end
            OP_ATTACH_EQ, OP_ATTACH_BTW: begin
                // range is checked before the slot type
                priority if ((r_item.op == OP_ATTACH_BTW) && bad_range) begin
                    exec_status = ST_BAD_RANGE;
                end else if (!type_ok) begin
                    exec_status = ST_WRONG_TYPE;
                end else if (no_entry) begin
                    exec_status = ST_NO_ENTRY;
                end else begin
                    ent_we    = 1'b1;
                    slot_we   = 1'b1;
                    slot_wcnt = CNT_W'(cur_cnt + 1'b1);
                    if (r_item.op == OP_ATTACH_BTW) begin
                        ent_wkind = ENT_INT_BTW;
                    end else if (cur_kind == KIND_CHAR) begin
                        ent_wkind  = ENT_CHAR_EQ;
                        ent_wfirst = {24'b0, r_item.value_a[7:0]};
                    end else begin
                        ent_wkind = ENT_INT_EQ;
                    end
                end
            end
            OP_DETACH: begin
                slot_we = r_in_range;
            end
            OP_CHECK: begin
                // a matching slot with no predicates passes
                exec_allowed = kind_match && (cur_cnt == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && slot_we) begin
            r_slot_kind_mem[slot_waddr] <= slot_wkind;
            r_slot_cnt_mem[slot_waddr]  <= slot_wcnt;
        end
        if (i_cmd.exec && ent_we) begin
            r_ent_kind_mem[ent_waddr]   <= ent_wkind;
            r_ent_first_mem[ent_waddr]  <= ent_wfirst;
            r_ent_second_mem[ent_waddr] <= r_item.value_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_ent_kind   <= r_ent_kind_mem[ent_raddr];
            r_ent_first  <= r_ent_first_mem[ent_raddr];
            r_ent_second <= r_ent_second_mem[ent_raddr];
        end
    end

    always_comb begin
        unique case (r_ent_kind)
            ENT_EMPTY:   hit = 1'b0;
            ENT_INT_EQ:  hit = (r_ent_first == r_item.value_a);
            ENT_INT_BTW: hit = ($signed(r_item.value_a) >= $signed(r_ent_first)) &&
                               ($signed(r_item.value_a) <= $signed(r_ent_second));
            ENT_CHAR_EQ: hit = (r_ent_first == {24'b0, r_item.value_a[7:0]});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= exec_status;
            r_allowed  <= exec_allowed;
            r_assigned <= exec_assigned;
            r_scan     <= '0;
        end else if (i_cmd.ent_test) begin
            r_allowed <= hit;
            r_scan    <= CNT_W'(r_scan + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
            r_slot_vld  <= '0;
        end else if (i_cmd.exec && set_vld) begin
            r_next_free             <= NF_W'(r_next_free + 1'b1);
            r_slot_vld[slot_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.status        <= r_status;
            r_out_item.allowed       <= r_allowed;
            r_out_item.assigned_slot <= r_assigned;
        end
    end

    always_comb begin
        o_sts.need_scan = (r_item.op == OP_CHECK) && kind_match && (cur_cnt != '0);
        o_sts.hit       = hit;
        o_sts.last      = (CNT_W'(r_scan + 1'b1) == cur_cnt);
        o_sts.out_busy  = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== sv/typed_slot_predicate_filter.sv =====
// Flow: an accepted item is registered, its slot is read into a register (LOOKUP), the
// operation is decided and written (DECIDE), and the result enters the output register (EMIT).
// A check of a slot with entries first walks them one entry at a time, an entry read (SCAN)
// then a test (TEST), up to the first hit or the last entry; the input stalls until EMIT is done.
// Reset (synchronous, active low) clears the state machine, the next-free counter,
// the per-slot valid bits and the output valid; there is no memory clearing pass.
`default_nettype none

module typed_slot_predicate_filter import tspf_pkg::*; #(
    parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
    parameter int ENTRIES_PER_SLOT = ENTRIES_PER_SLOT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tspf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tspf_dp #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== sv/tspf_checker.sv =====
`default_nettype none
`include "typed_slot_predicate_filter_macros.svh"

module tspf_checker import tspf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result holds
    `TSPF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

    // one item at a time: an accepted item blocks the input in the next cycle
    `TSPF_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

    // a passing check carries ok status and no slot index
    `TSPF_ASSERT_IMP(a_allowed_clean, i_clk, i_rst_n, o_out_valid && o_out_item.allowed, (o_out_item.status == ST_OK) && (o_out_item.assigned_slot == 4'd0), "allowed with status or slot set")

    // a failed operation never hands out a slot
    `TSPF_ASSERT_IMP(a_fail_no_slot, i_clk, i_rst_n, o_out_valid && (o_out_item.status != ST_OK), (o_out_item.assigned_slot == 4'd0) && !o_out_item.allowed, "failure with slot or allowed set")

endmodule

bind typed_slot_predicate_filter tspf_checker u_checker (.*);

`default_nettype wire
